/* rtl/core/morse_code_keyer_assert.svh */
// Assertion macros shared by the Morse keyer RTL.
`ifndef MORSE_CODE_KEYER_ASSERT_SVH
`define MORSE_CODE_KEYER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MCK_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger, outside reset.
`define MCK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after reset is applied.
`define MCK_ASSERT_AFTER_RESET(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) !(rstn) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mck_pkg.sv */
// Package with the types, constants and pattern table of the Morse keyer.
`default_nettype none

package mck_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_write;
    } in_t;

    typedef struct packed {
        logic        led_on;
        logic [12:0] hold_ms;
        logic [2:0]  text_code;
        logic        last_result;
    } out_t;

    localparam logic [2:0] TXT_NONE    = 3'd0;
    localparam logic [2:0] TXT_DOT     = 3'd1;
    localparam logic [2:0] TXT_DASH    = 3'd2;
    localparam logic [2:0] TXT_SPACE   = 3'd3;
    localparam logic [2:0] TXT_NEWLINE = 3'd4;

    localparam logic [10:0] DOT_DEFAULT = 11'd200;
    localparam logic [10:0] DOT_MAX     = 11'd2000;

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

    localparam logic [3:0] UNITS_GAP_LETTER = 4'd3;
    localparam logic [3:0] UNITS_GAP_WORD   = 4'd4;

    localparam logic [1:0] REG_DOT_TIME = 2'd0;

    typedef enum logic [2:0] {
        EM_SPACE0,
        EM_RUN,
        EM_ZERO,
        EM_GAP3,
        EM_WORD4,
        EM_NEWL
    } emit_kind_t;

    typedef struct packed {
        logic       load;
        logic       shift;
        logic       run_inc;
        logic       run_clr;
        logic       emit;
        emit_kind_t kind;
        logic       last;
        logic       set_letter;
        logic       set_word_gap;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_space;
        logic is_letter;
        logic eow;
        logic after_letter;
        logic at_word_gap;
        logic pat_zero;
        logic pat_msb;
        logic pat_next;
        logic out_free;
    } dp_stat_t;

    function automatic logic [15:0] pattern(input logic [4:0] idx);
        logic [15:0] p;
        case (idx)
            5'd0:    p = 16'hB800;
            5'd1:    p = 16'hEA80;
            5'd2:    p = 16'hEBA0;
            5'd3:    p = 16'hEA00;
            5'd4:    p = 16'h8000;
            5'd5:    p = 16'hAE80;
            5'd6:    p = 16'hEE80;
            5'd7:    p = 16'hAA00;
            5'd8:    p = 16'hA000;
            5'd9:    p = 16'hBBB8;
            5'd10:   p = 16'hEB80;
            5'd11:   p = 16'hBA80;
            5'd12:   p = 16'hEE00;
            5'd13:   p = 16'hE800;
            5'd14:   p = 16'hEEE0;
            5'd15:   p = 16'hBBA0;
            5'd16:   p = 16'hEEB8;
            5'd17:   p = 16'hBA00;
            5'd18:   p = 16'hA800;
            5'd19:   p = 16'hE000;
            5'd20:   p = 16'hAE00;
            5'd21:   p = 16'hAB80;
            5'd22:   p = 16'hBB80;
            5'd23:   p = 16'hEAE0;
            5'd24:   p = 16'hEBB8;
            5'd25:   p = 16'hEEA0;
            default: p = 16'h0000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mck_dp.sv */
// Datapath of the Morse keyer: pattern shifter, run counter, flags and result register.
`default_nettype none

module mck_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mck_pkg::in_t       s_data,
    input  wire logic [10:0]        dot_time,
    input  wire mck_pkg::ctrl_cmd_t cmd,
    output mck_pkg::dp_stat_t       stat,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mck_pkg::out_t           m_data
);

    logic        is_space_reg, is_space_next;
    logic        is_letter_reg, is_letter_next;
    logic        eow_reg, eow_next;
    logic [15:0] pat_reg, pat_next;
    logic [3:0]  run_reg, run_next;
    logic        after_letter_reg, after_letter_next;
    logic        at_word_gap_reg, at_word_gap_next;
    logic        m_valid_reg, m_valid_next;
    mck_pkg::out_t out_reg, out_next;

    logic [7:0]  ch;
    logic        upper;
    logic        lower;
    logic [7:0]  letter_off;
    logic [4:0]  units;
    logic [15:0] product;
    logic [2:0]  code;

    assign ch    = s_data.char_in;
    assign upper = (ch >= mck_pkg::CHAR_UPPER_A) && (ch <= mck_pkg::CHAR_UPPER_Z);
    assign lower = (ch >= mck_pkg::CHAR_LOWER_A) && (ch <= mck_pkg::CHAR_LOWER_Z);
    assign letter_off = (ch < mck_pkg::CHAR_LOWER_A) ? (ch - mck_pkg::CHAR_UPPER_A)
                                                     : (ch - mck_pkg::CHAR_LOWER_A);

    always_comb begin
        units = 5'd0;
        code  = mck_pkg::TXT_NONE;
        case (cmd.kind)
            mck_pkg::EM_SPACE0: begin
                units = 5'd0;
                code  = mck_pkg::TXT_SPACE;
            end
            mck_pkg::EM_RUN: begin
                units = {1'b0, run_reg} + 5'd1;
                code  = (run_reg == 4'd0) ? mck_pkg::TXT_DOT : mck_pkg::TXT_DASH;
            end
            mck_pkg::EM_ZERO: begin
                units = 5'd1;
                code  = mck_pkg::TXT_NONE;
            end
            mck_pkg::EM_GAP3: begin
                units = {1'b0, mck_pkg::UNITS_GAP_LETTER};
                code  = mck_pkg::TXT_NONE;
            end
            mck_pkg::EM_WORD4: begin
                units = {1'b0, mck_pkg::UNITS_GAP_WORD};
                code  = mck_pkg::TXT_SPACE;
            end
            mck_pkg::EM_NEWL: begin
                units = 5'd0;
                code  = mck_pkg::TXT_NEWLINE;
            end
            default: begin
                units = 5'd0;
                code  = mck_pkg::TXT_NONE;
            end
        endcase
    end

    assign product = 16'(units) * 16'(dot_time);

    always_comb begin
        is_space_next     = is_space_reg;
        is_letter_next    = is_letter_reg;
        eow_next          = eow_reg;
        pat_next          = pat_reg;
        run_next          = run_reg;
        after_letter_next = after_letter_reg;
        at_word_gap_next  = at_word_gap_reg;
        m_valid_next      = m_valid_reg & ~m_ready;
        out_next          = out_reg;

        if (cmd.load) begin
            is_space_next  = (ch == mck_pkg::CHAR_SPACE);
            is_letter_next = upper | lower;
            eow_next       = s_data.end_of_write;
            pat_next       = mck_pkg::pattern(letter_off[4:0]);
        end
        if (cmd.shift) begin
            pat_next = {pat_reg[14:0], 1'b0};
        end
        if (cmd.run_inc) begin
            run_next = run_reg + 4'd1;
        end
        if (cmd.run_clr || cmd.load) begin
            run_next = 4'd0;
        end
        if (cmd.set_letter) begin
            after_letter_next = 1'b1;
            at_word_gap_next  = 1'b0;
        end
        if (cmd.set_word_gap) begin
            after_letter_next = 1'b0;
            at_word_gap_next  = 1'b1;
        end
        if (cmd.emit) begin
            m_valid_next          = 1'b1;
            out_next.led_on       = (cmd.kind == mck_pkg::EM_RUN);
            out_next.hold_ms      = product[12:0];
            out_next.text_code    = code;
            out_next.last_result  = cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_letter_reg <= 1'b0;
            at_word_gap_reg  <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            after_letter_reg <= after_letter_next;
            at_word_gap_reg  <= at_word_gap_next;
            m_valid_reg      <= m_valid_next;
        end
        is_space_reg  <= is_space_next;
        is_letter_reg <= is_letter_next;
        eow_reg       <= eow_next;
        pat_reg       <= pat_next;
        run_reg       <= run_next;
        out_reg       <= out_next;
    end

    assign stat.is_space     = is_space_reg;
    assign stat.is_letter    = is_letter_reg;
    assign stat.eow          = eow_reg;
    assign stat.after_letter = after_letter_reg;
    assign stat.at_word_gap  = at_word_gap_reg;
    assign stat.pat_zero     = (pat_reg == 16'h0000);
    assign stat.pat_msb      = pat_reg[15];
    assign stat.pat_next     = pat_reg[14];
    assign stat.out_free     = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

/* rtl/core/mck_ctrl.sv */
// Controller state machine of the Morse keyer: sequences the segments of one request.
`default_nettype none

module mck_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mck_pkg::dp_stat_t stat,
    output mck_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PRESP,
        ST_SCAN,
        ST_GAP3,
        ST_WSP1,
        ST_WSP2,
        ST_WSP3
    } state_t;

    state_t state_reg, state_next;
    logic   newl_reg, newl_next;

    always_comb begin
        state_next = state_reg;
        newl_next  = newl_reg;
        cmd        = '0;
        cmd.kind   = mck_pkg::EM_SPACE0;

        case (state_reg)
            ST_IDLE: begin
                newl_next = 1'b0;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.is_space && !stat.at_word_gap) begin
                    state_next = ST_WSP1;
                end else if (stat.is_letter) begin
                    state_next = stat.after_letter ? ST_PRESP : ST_SCAN;
                end else if (stat.eow) begin
                    newl_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRESP: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = mck_pkg::EM_SPACE0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.pat_zero) begin
                    state_next = ST_GAP3;
                end else if (stat.pat_msb && stat.pat_next) begin
                    cmd.shift   = 1'b1;
                    cmd.run_inc = 1'b1;
                end else if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = stat.pat_msb ? mck_pkg::EM_RUN : mck_pkg::EM_ZERO;
                    cmd.shift   = 1'b1;
                    cmd.run_clr = 1'b1;
                end
            end
            ST_GAP3: begin
                if (stat.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.kind       = mck_pkg::EM_GAP3;
                    cmd.last       = ~stat.eow;
                    cmd.set_letter = 1'b1;
                    newl_next      = stat.eow;
                    state_next     = ST_IDLE;
                end
            end
            ST_WSP1: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = mck_pkg::EM_WORD4;
                    state_next = ST_WSP2;
                end
            end
            ST_WSP2: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = mck_pkg::EM_SPACE0;
                    state_next = ST_WSP3;
                end
            end
            ST_WSP3: begin
                if (stat.out_free) begin
                    cmd.emit         = 1'b1;
                    cmd.kind         = mck_pkg::EM_SPACE0;
                    cmd.last         = ~stat.eow;
                    cmd.set_word_gap = 1'b1;
                    newl_next        = stat.eow;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The newline of a finished request goes out before the next request is taken.
        if (state_reg == ST_IDLE && newl_reg) begin
            cmd.load   = 1'b0;
            state_next = ST_IDLE;
            newl_next  = newl_reg;
            if (stat.out_free) begin
                cmd.emit  = 1'b1;
                cmd.kind  = mck_pkg::EM_NEWL;
                cmd.last  = 1'b1;
                newl_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            newl_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            newl_reg  <= newl_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !newl_reg;

endmodule

`default_nettype wire

/* rtl/core/morse_code_keyer.sv */
// Morse keyer top level: configuration register, controller and datapath.
// Results are registered. One request at a time: a new request is accepted only when the
// controller is idle and no newline is pending, and result stalls hold the controller.
// Synchronous active-low reset idles the controller, clears letter flag and result valid,
// sets word gap and restores the default dot time.
`default_nettype none

`include "morse_code_keyer_assert.svh"

module morse_code_keyer (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire mck_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output mck_pkg::out_t      m_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [10:0] dot_time_reg, dot_time_next;
    logic [10:0] wr_val;
    logic        wr_en;

    mck_pkg::ctrl_cmd_t cmd;
    mck_pkg::dp_stat_t  stat;

    assign wr_en  = psel && penable && pwrite && (paddr[2] == mck_pkg::REG_DOT_TIME[0]);
    assign wr_val = pwdata[10:0];

    always_comb begin
        dot_time_next = dot_time_reg;
        if (wr_en) begin
            if (wr_val == 11'd0 || wr_val > mck_pkg::DOT_MAX) begin
                dot_time_next = mck_pkg::DOT_DEFAULT;
            end else begin
                dot_time_next = wr_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_time_reg <= mck_pkg::DOT_DEFAULT;
        end else begin
            dot_time_reg <= dot_time_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mck_pkg::REG_DOT_TIME[0]) ? {21'd0, dot_time_reg} : 32'd0;

    mck_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mck_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .dot_time (dot_time_reg),
        .cmd      (cmd),
        .stat     (stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `MCK_ASSERT_AFTER_RESET(a_reset_clears_valid, aclk, aresetn, !m_valid,
                            "result valid after reset")
    `MCK_ASSERT_ALWAYS(a_dot_in_range, aclk, aresetn,
                       dot_time_reg != 11'd0 && dot_time_reg <= mck_pkg::DOT_MAX,
                       "dot time out of range")
    `MCK_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready,
                     "request taken while busy")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the Morse keyer: directed, configuration and random request tests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_DOT      = 3'(4 * mck_pkg::REG_DOT_TIME);
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         IDLE_PCT      = 7;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    mck_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready = 1'b0;
    mck_pkg::out_t m_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    logic          steady = 1'b0;

    logic [10:0]   dot_ms;
    logic          after_letter_q;
    logic          at_word_gap_q;
    mck_pkg::out_t seg_q[$];
    mck_pkg::out_t step_buf[10];
    int            step_n;

    int            mismatch_cnt = 0;
    int            seg_seen = 0;
    int            req_sent = 0;
    int            directed_cnt = 0;
    int            dot_writes = 0;

    morse_code_keyer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic string morse_of(input int idx);
        case (idx)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            default: return "--..";
        endcase
    endfunction

    function automatic void add_seg(input logic led, input int units, input logic [2:0] code);
        mck_pkg::out_t s;
        s.led_on      = led;
        s.hold_ms     = 13'(units * int'(dot_ms));
        s.text_code   = code;
        s.last_result = 1'b0;
        step_buf[step_n] = s;
        step_n++;
    endfunction

    function automatic void predict_segments(input mck_pkg::in_t req);
        string pat;
        int    idx;
        int    i;
        step_n = 0;
        if (req.char_in == mck_pkg::CHAR_SPACE) begin
            if (!at_word_gap_q) begin
                add_seg(1'b0, int'(mck_pkg::UNITS_GAP_WORD), mck_pkg::TXT_SPACE);
                add_seg(1'b0, 0, mck_pkg::TXT_SPACE);
                add_seg(1'b0, 0, mck_pkg::TXT_SPACE);
                at_word_gap_q  = 1'b1;
                after_letter_q = 1'b0;
            end
        end else if ((req.char_in >= mck_pkg::CHAR_UPPER_A &&
                      req.char_in <= mck_pkg::CHAR_UPPER_Z) ||
                     (req.char_in >= mck_pkg::CHAR_LOWER_A &&
                      req.char_in <= mck_pkg::CHAR_LOWER_Z)) begin
            idx = (req.char_in >= mck_pkg::CHAR_LOWER_A)
                ? int'(req.char_in - mck_pkg::CHAR_LOWER_A)
                : int'(req.char_in - mck_pkg::CHAR_UPPER_A);
            pat = morse_of(idx);
            if (after_letter_q)
                add_seg(1'b0, 0, mck_pkg::TXT_SPACE);
            for (i = 0; i < pat.len(); i++) begin
                if (i > 0)
                    add_seg(1'b0, 1, mck_pkg::TXT_NONE);
                if (pat[i] == "-")
                    add_seg(1'b1, 3, mck_pkg::TXT_DASH);
                else
                    add_seg(1'b1, 1, mck_pkg::TXT_DOT);
            end
            add_seg(1'b0, int'(mck_pkg::UNITS_GAP_LETTER), mck_pkg::TXT_NONE);
            after_letter_q = 1'b1;
            at_word_gap_q  = 1'b0;
        end
        if (req.end_of_write)
            add_seg(1'b0, 0, mck_pkg::TXT_NEWLINE);
        if (step_n > 0)
            step_buf[step_n - 1].last_result = 1'b1;
        for (i = 0; i < step_n; i++)
            seg_q.push_back(step_buf[i]);
    endfunction

    function automatic void predict_dot_write(input logic [2:0] addr, input logic [31:0] data);
        logic [10:0] v;
        v = data[10:0];
        if (addr != ADDR_DOT)
            return;
        dot_ms = (v < 11'd1 || v > mck_pkg::DOT_MAX) ? mck_pkg::DOT_DEFAULT : v;
    endfunction

    task automatic note_mismatch(input string what, input mck_pkg::out_t want,
                                 input mck_pkg::out_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display({"[%0t] %s: expected led=%0d hold=%0d text=%0d last=%0d, ",
                      "got led=%0d hold=%0d text=%0d last=%0d"},
                     $realtime, what, want.led_on, want.hold_ms, want.text_code,
                     want.last_result, got.led_on, got.hold_ms, got.text_code,
                     got.last_result);
    endtask

    always @(posedge aclk) begin
        mck_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            seg_seen++;
            if (seg_q.size() == 0) begin
                note_mismatch("result with none pending", '0, m_data);
            end else begin
                want = seg_q.pop_front();
                if (m_data.led_on !== want.led_on || m_data.hold_ms !== want.hold_ms ||
                    m_data.text_code !== want.text_code ||
                    m_data.last_result !== want.last_result)
                    note_mismatch("segment differs", want, m_data);
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic eow);
        mck_pkg::in_t req;
        req.char_in      = ch;
        req.end_of_write = eow;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predict_segments(req);
        req_sent++;
    endtask

    task automatic send_text(input string txt, input logic eow_last);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_char(txt[i], eow_last && (i == txt.len() - 1));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (seg_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        predict_dot_write(addr, data);
        dot_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_dot_readback();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DOT;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {21'd0, dot_ms}) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("[%0t] dot time readback: expected %0d, got %0d",
                         $realtime, dot_ms, got);
        end
        @(posedge aclk);
    endtask

    task automatic test_directed();
        check_dot_readback();
        send_char(mck_pkg::CHAR_SPACE, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(mck_pkg::CHAR_UPPER_A - 8'd1, 1'b0);
        send_text("AZ", 1'b0);
        send_char(mck_pkg::CHAR_UPPER_Z + 8'd1, 1'b0);
        send_char(mck_pkg::CHAR_LOWER_A - 8'd1, 1'b0);
        send_text("az", 1'b0);
        send_char(mck_pkg::CHAR_LOWER_Z + 8'd1, 1'b0);
        send_text("  Q", 1'b1);
        send_char("J", 1'b1);
        send_text("e ", 1'b1);
        send_char(8'h80, 1'b1);
        send_char("T", 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'hA0, 1'b1);
        directed_cnt = req_sent;
    endtask

    task automatic test_dot_time();
        logic [31:0] settings [0:6];
        int i;
        settings = '{32'd1, 32'd2000, 32'd0, 32'd2001, 32'd2047, 32'hFFFF_F805, 32'd137};
        for (i = 0; i < 7; i++) begin
            wait_idle();
            apb_write(ADDR_DOT, settings[i]);
            check_dot_readback();
            send_text("TE Y", 1'b1);
        end
        wait_idle();
        apb_write(ADDR_UNMAPPED, 32'd1);
        check_dot_readback();
        send_text("M ", 1'b0);
    endtask

    task automatic test_random_text();
        int          i;
        int          pick;
        logic [7:0]  ch;
        wait_idle();
        apb_write(ADDR_DOT, $urandom_range(2000, 1));
        for (i = 0; i < 120; i++) begin
            steady = (i >= 40 && i < 80);
            if (i == 80) begin
                wait_idle();
                apb_write(ADDR_DOT, $urandom_range(2000, 1));
            end
            pick = $urandom_range(99);
            if (pick < 78)
                ch = 8'(($urandom_range(1) ? mck_pkg::CHAR_LOWER_A : mck_pkg::CHAR_UPPER_A)
                        + $urandom_range(25));
            else if (pick < 90)
                ch = mck_pkg::CHAR_SPACE;
            else
                ch = 8'($urandom_range(255));
            send_char(ch, $urandom_range(99) < 10);
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        dot_ms         = mck_pkg::DOT_DEFAULT;
        after_letter_q = 1'b0;
        at_word_gap_q  = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_dot_time();
        test_random_text();
        wait_idle();

        $display("Sent %0d requests (%0d directed) and checked %0d segments",
                 req_sent, directed_cnt, seg_seen);
        $display("over %0d dot time writes; mismatches found: %0d.", dot_writes, mismatch_cnt);
        if (mismatch_cnt == 0 && seg_q.size() == 0)
            $display("morse_code_keyer: match");
        else
            $display("morse_code_keyer: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run stopped: %0d segments still pending.", seg_q.size());
        $display("morse_code_keyer: mismatch");
        $finish;
    end

endmodule
